/* hdl/pgc_pkg.sv */
`default_nettype none
package pgc_pkg;

  // Datapath widths.
  localparam int unsigned POS_W    = 32;
  localparam int unsigned HEAD_W   = 16;
  localparam int unsigned GAIN_W   = 16;
  localparam int unsigned DIFF_W   = 33;
  localparam int unsigned MAG_W    = 36;
  localparam int unsigned MUL_B_W  = 18;
  localparam int unsigned PROD_W   = 54;
  localparam int unsigned Z_W      = 25;
  localparam int unsigned LAMBDA_W = 17;
  localparam int unsigned ANG_W    = 18;
  localparam int unsigned RHO_W    = 34;
  localparam int unsigned RAW_W    = 24;
  localparam int unsigned RATE_W   = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Angles in Q3.13, CORDIC angle in Q3.21.
  localparam logic signed [ANG_W-1:0]  PI_Q13      = 18'sd25736;
  localparam logic signed [ANG_W-1:0]  NEG_PI_Q13  = -18'sd25736;
  localparam logic signed [ANG_W-1:0]  TWO_PI_Q13  = 18'sd51472;
  localparam logic signed [ANG_W-1:0]  STOP_ANGLE  = 18'sd715;
  localparam logic signed [Z_W-1:0]    HALF_PI_Q21 = 25'sd3294199;
  localparam logic signed [Z_W-1:0]    Z_ROUND     = 25'sd128;
  localparam logic [Z_W-1:0]           Z_ONE       = 25'd1;
  localparam logic signed [RAW_W-1:0]  RATE_MAX    = 24'sd6434;
  localparam logic signed [RAW_W-1:0]  RATE_MIN    = -24'sd32768;
  localparam logic signed [MUL_B_W-1:0] INV_GAIN_Q16 = 18'sd39797;
  localparam logic signed [PROD_W-1:0] ROUND_Q16   = 54'sd32768;
  localparam logic signed [PROD_W-1:0] ROUND_Q12   = 54'sd2048;
  localparam logic [RHO_W-1:0]         STOP_RHO    = 34'd13107;

  // Register reset values.
  localparam logic signed [GAIN_W-1:0] GAIN_DISTANCE_RST      = 16'sd2048;
  localparam logic signed [GAIN_W-1:0] GAIN_BEARING_RST       = 16'sd6144;
  localparam logic signed [GAIN_W-1:0] GAIN_FINAL_HEADING_RST = -16'sd2458;
  localparam logic signed [POS_W-1:0]  FIXED_SPEED_RST        = 32'sd6554;

  typedef enum logic [1:0] {
    ACT_ROBOT_POSE = 2'd0,
    ACT_GOAL_POSE  = 2'd1,
    ACT_TICK       = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_DISTANCE      = 3'd0,
    CFG_GAIN_BEARING       = 3'd1,
    CFG_GAIN_FINAL_HEADING = 3'd2,
    CFG_REVERSE_MODE       = 3'd3,
    CFG_FIXED_SPEED_MODE   = 3'd4,
    CFG_FIXED_SPEED        = 3'd5
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CORDIC,
    S_RHO,
    S_ROUND,
    S_SPEED,
    S_ALPHA,
    S_BETA,
    S_RATE,
    S_WRITE
  } state_e;

  // Elementary rotation angles atan(2^-i) in Q3.21.
  function automatic logic signed [Z_W-1:0] atan_q21(input logic [5:0] idx);
    logic signed [Z_W-1:0] r;
    r = '0;
    case (idx)
      6'd0: r = 25'sd1647099;
      6'd1: r = 25'sd972340;
      6'd2: r = 25'sd513757;
      6'd3: r = 25'sd260791;
      6'd4: r = 25'sd130902;
      6'd5: r = 25'sd65515;
      6'd6: r = 25'sd32765;
      default: begin
        if (idx <= 6'd21) begin
          r = $signed(Z_ONE << (6'd21 - idx));
        end
      end
    endcase
    return r;
  endfunction

  // One correction step is enough for every angle difference this block forms.
  function automatic logic signed [ANG_W-1:0] wrap_angle(input logic signed [ANG_W-1:0] a);
    logic signed [ANG_W-1:0] r;
    if (a > PI_Q13) begin
      r = a - TWO_PI_Q13;
    end else if (a < NEG_PI_Q13) begin
      r = a + TWO_PI_Q13;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

/* hdl/polar_go_to_goal_controller.sv */
`default_nettype none
// Go-to-goal pose controller for a unicycle robot, in polar coordinates.
// Input channel (in_valid_i / in_stall_o): one transaction per item; action selects
// a robot pose update, a goal pose update or a control tick. Only ticks produce an
// output transaction (out_valid_o / out_stall_i) with speed and angular rate.
// Pose and goal updates can be sent back to back.
// A tick with no active goal goes to the write step, which loads an all-zero result
// into the output register. A tick with an active goal runs one CORDIC vectoring
// pass on the add/shift unit, then seven steps that issue four products on one
// shared registered multiplier, round, saturate and load the output register.
// in_stall_o is high until the block is idle again, so a new item is not taken
// while a tick is in progress.
// The result sits in an output register; while the receiver stalls it holds, the
// block may accept pose updates, and a following tick waits at its final step until
// the output register is free.
// Configuration writes (cfg_we_i, cfg_index_i, cfg_data_i) take effect at the clock
// edge and are to be issued only while the block is idle.
// Reset clears the poses, drops the active goal, restores the register defaults
// and empties the output register.
module polar_go_to_goal_controller
  import pgc_pkg::*;
#(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic signed [POS_W-1:0]   pos_x_i,
  input  logic signed [POS_W-1:0]   pos_y_i,
  input  logic signed [HEAD_W-1:0]  heading_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [POS_W-1:0]   linear_speed_o,
  output logic signed [RATE_W-1:0]  angular_rate_o,
  output logic                      goal_reached_o,
  output logic                      goal_active_o
);

  // Configuration registers.
  logic signed [GAIN_W-1:0] gain_distance_q, gain_bearing_q, gain_final_heading_q;
  logic                     reverse_mode_q, fixed_speed_mode_q;
  logic signed [POS_W-1:0]  fixed_speed_q;

  // Architectural state.
  logic signed [POS_W-1:0]  robot_x_q, robot_x_d, robot_y_q, robot_y_d;
  logic signed [POS_W-1:0]  goal_x_q, goal_x_d, goal_y_q, goal_y_d;
  logic signed [HEAD_W-1:0] robot_heading_q, robot_heading_d;
  logic signed [HEAD_W-1:0] goal_heading_q, goal_heading_d;
  logic                     goal_pending_q, goal_pending_d;

  state_e state_q, state_d;

  // Working registers of one tick.
  logic                     active_q, active_d;
  logic signed [ANG_W-1:0]  alpha_q, alpha_d, beta_q, beta_d, dtheta_q, dtheta_d;
  logic                     neg_q, neg_d;
  logic [RHO_W-1:0]         rho_q, rho_d;
  logic signed [POS_W-1:0]  speed_q, speed_d;
  logic signed [PROD_W-1:0] acc_q, acc_d;
  logic signed [RAW_W-1:0]  raw_q, raw_d;

  // Output register.
  logic                     out_valid_q, out_valid_d;
  logic signed [POS_W-1:0]  out_speed_q, out_speed_d;
  logic signed [RATE_W-1:0] out_rate_q, out_rate_d;
  logic                     out_reached_q, out_reached_d, out_active_q, out_active_d;

  // Shared units.
  logic                       cordic_start;
  logic signed [DIFF_W-1:0]   dx, dy;
  logic                       cordic_done;
  logic signed [MAG_W-1:0]    cordic_mag;
  logic signed [LAMBDA_W-1:0] lambda;
  logic signed [MAG_W-1:0]    mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [PROD_W-1:0]   mul_p;

  // Intermediate values.
  logic                       in_accept, out_free, reached;
  logic signed [ANG_W-1:0]    alpha_raw, dtheta_raw, dtheta_wrap;
  logic signed [PROD_W-1:0]   rho_sum, speed_sum, speed_sh, rate_sum, rate_sh;
  logic [PROD_W-32:0]         speed_top;
  logic signed [RAW_W-1:0]    rate_n;
  logic signed [RATE_W-1:0]   rate_sat;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  assign dx = DIFF_W'(goal_x_q) - DIFF_W'(robot_x_q);
  assign dy = DIFF_W'(goal_y_q) - DIFF_W'(robot_y_q);

  pgc_cordic #(
    .STEPS(CORDIC_STEPS)
  ) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .dx_i    (dx),
    .dy_i    (dy),
    .done_o  (cordic_done),
    .mag_o   (cordic_mag),
    .lambda_o(lambda)
  );

  pgc_mult u_mult (
    .clk_i(clk_i),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (mul_p)
  );

  // Angle terms, taken once the CORDIC pass has finished.
  assign alpha_raw   = ANG_W'(lambda) - ANG_W'(robot_heading_q);
  assign dtheta_raw  = ANG_W'(robot_heading_q) - ANG_W'(goal_heading_q);
  assign dtheta_wrap = wrap_angle(dtheta_raw);

  assign rho_sum   = mul_p + ROUND_Q16;
  assign speed_sum = mul_p + ROUND_Q12;
  assign speed_sh  = speed_sum >>> 12;
  assign speed_top = speed_sh[PROD_W-1:31];
  assign rate_sum  = (reverse_mode_q ? acc_q : acc_q + mul_p) + ROUND_Q12;
  assign rate_sh   = rate_sum >>> 12;

  assign rate_n = neg_q ? -raw_q : raw_q;
  always_comb begin
    if (rate_n > RATE_MAX) begin
      rate_sat = RATE_W'(RATE_MAX);
    end else if (rate_n < RATE_MIN) begin
      rate_sat = RATE_W'(RATE_MIN);
    end else begin
      rate_sat = RATE_W'(rate_n);
    end
  end

  assign reached = active_q && (rho_q < STOP_RHO) && (dtheta_q < STOP_ANGLE);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_RHO: begin
        mul_a = cordic_mag;
        mul_b = INV_GAIN_Q16;
      end
      S_SPEED: begin
        mul_a = $signed(MAG_W'(rho_q));
        mul_b = MUL_B_W'(gain_distance_q);
      end
      S_ALPHA: begin
        mul_a = MAG_W'(alpha_q);
        mul_b = MUL_B_W'(gain_bearing_q);
      end
      S_BETA: begin
        mul_a = MAG_W'(beta_q);
        mul_b = MUL_B_W'(gain_final_heading_q);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d         = state_q;
    robot_x_d       = robot_x_q;
    robot_y_d       = robot_y_q;
    robot_heading_d = robot_heading_q;
    goal_x_d        = goal_x_q;
    goal_y_d        = goal_y_q;
    goal_heading_d  = goal_heading_q;
    goal_pending_d  = goal_pending_q;
    active_d        = active_q;
    alpha_d         = alpha_q;
    beta_d          = beta_q;
    dtheta_d        = dtheta_q;
    neg_d           = neg_q;
    rho_d           = rho_q;
    speed_d         = speed_q;
    acc_d           = acc_q;
    raw_d           = raw_q;
    cordic_start    = 1'b0;
    out_valid_d     = out_valid_q && out_stall_i;
    out_speed_d     = out_speed_q;
    out_rate_d      = out_rate_q;
    out_reached_d   = out_reached_q;
    out_active_d    = out_active_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          unique case (action_e'(action_i))
            ACT_ROBOT_POSE: begin
              robot_x_d       = pos_x_i;
              robot_y_d       = pos_y_i;
              robot_heading_d = heading_i;
            end
            ACT_GOAL_POSE: begin
              goal_x_d       = pos_x_i;
              goal_y_d       = pos_y_i;
              goal_heading_d = heading_i;
              goal_pending_d = 1'b1;
            end
            ACT_TICK: begin
              active_d = goal_pending_q;
              if (goal_pending_q) begin
                cordic_start = 1'b1;
                state_d      = S_CORDIC;
              end else begin
                state_d = S_WRITE;
              end
            end
            default: ;
          endcase
        end
      end
      S_CORDIC: begin
        if (cordic_done) begin
          state_d = S_RHO;
        end
      end
      S_RHO: begin
        alpha_d  = wrap_angle(alpha_raw);
        beta_d   = ANG_W'(goal_heading_q) - ANG_W'(lambda);
        dtheta_d = (dtheta_wrap < 0) ? -dtheta_wrap : dtheta_wrap;
        neg_d    = reverse_mode_q && !(lambda > LAMBDA_W'(goal_heading_q));
        state_d  = S_ROUND;
      end
      S_ROUND: begin
        rho_d   = rho_sum[RHO_W+15:16];
        state_d = S_SPEED;
      end
      S_SPEED: begin
        state_d = S_ALPHA;
      end
      S_ALPHA: begin
        if (fixed_speed_mode_q) begin
          speed_d = fixed_speed_q;
        end else if ((&speed_top) || !(|speed_top)) begin
          speed_d = speed_sh[POS_W-1:0];
        end else begin
          speed_d = speed_top[PROD_W-32] ? {1'b1, {(POS_W-1){1'b0}}}
                                         : {1'b0, {(POS_W-1){1'b1}}};
        end
        state_d = S_BETA;
      end
      S_BETA: begin
        acc_d   = mul_p;
        state_d = S_RATE;
      end
      S_RATE: begin
        raw_d   = rate_sh[RAW_W-1:0];
        state_d = S_WRITE;
      end
      S_WRITE: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_speed_d   = active_q ? speed_q : '0;
          out_rate_d    = active_q ? rate_sat : '0;
          out_reached_d = reached;
          out_active_d  = active_q;
          if (reached) begin
            goal_pending_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      robot_x_q       <= '0;
      robot_y_q       <= '0;
      robot_heading_q <= '0;
      goal_x_q        <= '0;
      goal_y_q        <= '0;
      goal_heading_q  <= '0;
      goal_pending_q  <= 1'b0;
      active_q        <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      state_q         <= state_d;
      robot_x_q       <= robot_x_d;
      robot_y_q       <= robot_y_d;
      robot_heading_q <= robot_heading_d;
      goal_x_q        <= goal_x_d;
      goal_y_q        <= goal_y_d;
      goal_heading_q  <= goal_heading_d;
      goal_pending_q  <= goal_pending_d;
      active_q        <= active_d;
      out_valid_q     <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    alpha_q       <= alpha_d;
    beta_q        <= beta_d;
    dtheta_q      <= dtheta_d;
    neg_q         <= neg_d;
    rho_q         <= rho_d;
    speed_q       <= speed_d;
    acc_q         <= acc_d;
    raw_q         <= raw_d;
    out_speed_q   <= out_speed_d;
    out_rate_q    <= out_rate_d;
    out_reached_q <= out_reached_d;
    out_active_q  <= out_active_d;
  end

  // Configuration port; indexes past the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_distance_q      <= GAIN_DISTANCE_RST;
      gain_bearing_q       <= GAIN_BEARING_RST;
      gain_final_heading_q <= GAIN_FINAL_HEADING_RST;
      reverse_mode_q       <= 1'b0;
      fixed_speed_mode_q   <= 1'b0;
      fixed_speed_q        <= FIXED_SPEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_GAIN_DISTANCE:      gain_distance_q      <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_BEARING:       gain_bearing_q       <= cfg_data_i[GAIN_W-1:0];
        CFG_GAIN_FINAL_HEADING: gain_final_heading_q <= cfg_data_i[GAIN_W-1:0];
        CFG_REVERSE_MODE:       reverse_mode_q       <= cfg_data_i[0];
        CFG_FIXED_SPEED_MODE:   fixed_speed_mode_q   <= cfg_data_i[0];
        CFG_FIXED_SPEED:        fixed_speed_q        <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign linear_speed_o = out_speed_q;
  assign angular_rate_o = out_rate_q;
  assign goal_reached_o = out_reached_q;
  assign goal_active_o  = out_active_q;

endmodule
`default_nettype wire

/* hdl/pgc_mult.sv */
`default_nettype none
module pgc_mult
  import pgc_pkg::*;
(
  input  logic                     clk_i,
  input  logic signed [MAG_W-1:0]   a_i,
  input  logic signed [MUL_B_W-1:0] b_i,
  output logic signed [PROD_W-1:0]  p_o
);

  logic signed [PROD_W-1:0] p_q;
  logic signed [PROD_W-1:0] p_d;

  assign p_d = PROD_W'(a_i) * PROD_W'(b_i);

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
  end

  assign p_o = p_q;

endmodule
`default_nettype wire

/* hdl/pgc_cordic.sv */
`default_nettype none
module pgc_cordic
  import pgc_pkg::*;
#(
  parameter int unsigned STEPS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic signed [DIFF_W-1:0]   dx_i,
  input  logic signed [DIFF_W-1:0]   dy_i,
  output logic                       done_o,
  output logic signed [MAG_W-1:0]    mag_o,
  output logic signed [LAMBDA_W-1:0] lambda_o
);

  localparam int unsigned CW = $clog2(STEPS);
  localparam logic [CW-1:0] LAST = CW'(STEPS - 1);

  logic signed [MAG_W-1:0] x_q, x_d, y_q, y_d, xs, ys, dx_ext, dy_ext;
  logic signed [Z_W-1:0]   z_q, z_d, z_rnd, atan_v;
  logic [CW-1:0]           cnt_q, cnt_d;
  logic                    run_q, run_d, done_q, done_d, zero_q, zero_d;

  assign dx_ext = MAG_W'(dx_i);
  assign dy_ext = MAG_W'(dy_i);
  assign xs     = x_q >>> cnt_q;
  assign ys     = y_q >>> cnt_q;
  assign atan_v = atan_q21(6'(cnt_q));

  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = done_q;
    zero_d = zero_q;
    if (start_i) begin
      // Rotate the left half plane by a quarter turn so the loop converges.
      zero_d = (dx_i == '0) && (dy_i == '0);
      cnt_d  = '0;
      run_d  = 1'b1;
      done_d = 1'b0;
      if (dx_ext < 0) begin
        if (dy_ext >= 0) begin
          x_d = dy_ext;
          y_d = -dx_ext;
          z_d = HALF_PI_Q21;
        end else begin
          x_d = -dy_ext;
          y_d = dx_ext;
          z_d = -HALF_PI_Q21;
        end
      end else begin
        x_d = dx_ext;
        y_d = dy_ext;
        z_d = '0;
      end
    end else if (run_q) begin
      if (y_q >= 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_v;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_v;
      end
      if (cnt_q == LAST) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
      zero_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      run_q  <= run_d;
      done_q <= done_d;
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign z_rnd    = z_q + Z_ROUND;
  assign done_o   = done_q;
  assign mag_o    = x_q;
  assign lambda_o = zero_q ? '0 : $signed(z_rnd[Z_W-1:8]);

endmodule
`default_nettype wire

/* hdl/pgc_checker.sv */
`default_nettype none
module pgc_checker
  import pgc_pkg::*;
(
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic [1:0]                action_i,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic signed [POS_W-1:0]   linear_speed_o,
  input logic signed [RATE_W-1:0]  angular_rate_o,
  input logic                      goal_reached_o,
  input logic                      goal_active_o
);

  // A stalled result transaction stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // The angular rate never exceeds an eighth of a turn per second.
  a_rate_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (angular_rate_o <= 16'sd6434))
    else $error("angular rate above upper clamp");

  // Without an active goal every field is zero.
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !goal_active_o |->
      (linear_speed_o == '0) && (angular_rate_o == '0) && !goal_reached_o)
    else $error("inactive tick gave a nonzero command");

  // Reaching the goal is only reported for an active goal.
  a_reached_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && goal_reached_o |-> goal_active_o)
    else $error("goal reached without an active goal");

  // A tick transaction always occupies the block for at least the next cycle.
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (action_i == ACT_TICK) |=> in_stall_o)
    else $error("block ready right after a tick");

endmodule

bind polar_go_to_goal_controller pgc_checker u_pgc_checker (.*);
`default_nettype wire

/* tb/polar_go_to_goal_controller_tb.sv */
module polar_go_to_goal_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pgc_pkg::*;

  localparam int unsigned STEPS = 16;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 190;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

  localparam longint ANG_PI = 25736;
  localparam longint ANG_TWO_PI = 51472;
  localparam longint RATE_CEIL = 6434;
  localparam longint RATE_FLOOR = -32768;
  localparam longint RHO_STOP = 13107;
  localparam longint ANG_STOP = 715;
  localparam longint QUARTER_TURN_Z = 3294199;
  localparam longint MAG_SCALE = 39797;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    logic [31:0] speed;
    logic [15:0] rate;
    logic        reached;
    logic        active;
  } ctrl_cmd_t;

  // Tracks pose, goal and gains as the block sees them and keeps the motion
  // commands still owed by the block, oldest first.
  class go_to_goal_tracker;
    longint rob_x, rob_y, rob_h;
    longint tgt_x, tgt_y, tgt_h;
    bit tgt_live;
    longint k_dist, k_bear, k_final;
    bit reverse_law, const_speed_on;
    longint const_speed;
    ctrl_cmd_t pending_cmds[$];
    int unsigned mismatches;

    function new();
      rob_x = 0; rob_y = 0; rob_h = 0;
      tgt_x = 0; tgt_y = 0; tgt_h = 0;
      tgt_live = 1'b0;
      k_dist = GAIN_DISTANCE_RST;
      k_bear = GAIN_BEARING_RST;
      k_final = GAIN_FINAL_HEADING_RST;
      reverse_law = 1'b0;
      const_speed_on = 1'b0;
      const_speed = FIXED_SPEED_RST;
      mismatches = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
      case (idx)
        CFG_GAIN_DISTANCE:      k_dist = $signed(data[15:0]);
        CFG_GAIN_BEARING:       k_bear = $signed(data[15:0]);
        CFG_GAIN_FINAL_HEADING: k_final = $signed(data[15:0]);
        CFG_REVERSE_MODE:       reverse_law = data[0];
        CFG_FIXED_SPEED_MODE:   const_speed_on = data[0];
        CFG_FIXED_SPEED:        const_speed = $signed(data);
        default: ;
      endcase
    endfunction

    function longint rot_angle(input int i);
      case (i)
        0: return 1647099;
        1: return 972340;
        2: return 513757;
        3: return 260791;
        4: return 130902;
        5: return 65515;
        6: return 32765;
        default: return (i <= 21) ? (64'sd1 <<< (21 - i)) : 64'sd0;
      endcase
    endfunction

    function longint wrap_pi(input longint a);
      longint r;
      r = a;
      while (r > ANG_PI) r -= ANG_TWO_PI;
      while (r < -ANG_PI) r += ANG_TWO_PI;
      return r;
    endfunction

    function longint clamp64(input longint v, input longint lo, input longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Vectoring pass: the left half plane is first turned by a quarter turn,
    // then the vector is rotated onto the x axis. Angle runs in Q3.21.
    function void to_polar(input longint dx, input longint dy,
                           output longint rho, output longint lam);
      longint x, y, z, t, xs, ys;
      int i;
      x = dx; y = dy; z = 0;
      if (dx == 0 && dy == 0) begin
        rho = 0;
        lam = 0;
        return;
      end
      if (x < 0) begin
        t = x;
        if (y >= 0) begin
          x = y; y = -t; z = QUARTER_TURN_Z;
        end else begin
          x = -y; y = t; z = -QUARTER_TURN_Z;
        end
      end
      for (i = 0; i < STEPS; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += rot_angle(i);
        end else begin
          x -= ys; y += xs; z -= rot_angle(i);
        end
      end
      rho = (x * MAG_SCALE + 32768) >>> 16;
      lam = (z + 128) >>> 8;
    endfunction

    function ctrl_cmd_t predict_tick();
      ctrl_cmd_t c;
      longint rho, lam, alpha, beta, spd, rate, dth;
      c = '{default: '0};
      if (!tgt_live) return c;
      to_polar(tgt_x - rob_x, tgt_y - rob_y, rho, lam);
      alpha = wrap_pi(lam - rob_h);
      beta = tgt_h - lam;
      if (const_speed_on) spd = const_speed;
      else spd = clamp64((k_dist * rho + 2048) >>> 12, S32_MIN, S32_MAX);
      if (reverse_law) begin
        rate = (k_bear * alpha + 2048) >>> 12;
        if (!(lam > tgt_h)) rate = -rate;
      end else begin
        rate = (k_bear * alpha + k_final * beta + 2048) >>> 12;
      end
      rate = clamp64(rate, RATE_FLOOR, RATE_CEIL);
      dth = wrap_pi(rob_h - tgt_h);
      if (dth < 0) dth = -dth;
      c.reached = (rho < RHO_STOP) && (dth < ANG_STOP);
      // The goal is dropped only after the command for this tick is formed.
      if (c.reached) tgt_live = 1'b0;
      c.speed = spd[31:0];
      c.rate = rate[15:0];
      c.active = 1'b1;
      return c;
    endfunction

    function void accept_item(input logic [1:0] act, input logic signed [31:0] px,
                              input logic signed [31:0] py, input logic signed [15:0] ph);
      case (act)
        ACT_ROBOT_POSE: begin
          rob_x = px; rob_y = py; rob_h = ph;
        end
        ACT_GOAL_POSE: begin
          tgt_x = px; tgt_y = py; tgt_h = ph;
          tgt_live = 1'b1;
        end
        ACT_TICK: pending_cmds.push_back(predict_tick());
        default: ;
      endcase
    endfunction

    function void check_command(input logic [31:0] speed, input logic [15:0] rate,
                                input logic reached, input logic active);
      ctrl_cmd_t want;
      if (pending_cmds.size() == 0) begin
        $display("%0t: unexpected command speed %0d rate %0d reached %b active %b",
                 $time, $signed(speed), $signed(rate), reached, active);
        mismatches++;
        return;
      end
      want = pending_cmds.pop_front();
      if (want.speed !== speed) begin
        $display("%0t: linear_speed expected %0d actual %0d",
                 $time, $signed(want.speed), $signed(speed));
        mismatches++;
      end
      if (want.rate !== rate) begin
        $display("%0t: angular_rate expected %0d actual %0d",
                 $time, $signed(want.rate), $signed(rate));
        mismatches++;
      end
      if (want.reached !== reached) begin
        $display("%0t: goal_reached expected %b actual %b", $time, want.reached, reached);
        mismatches++;
      end
      if (want.active !== active) begin
        $display("%0t: goal_active expected %b actual %b", $time, want.active, active);
        mismatches++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic in_valid_i;
  logic in_stall_o;
  logic [1:0] action_i;
  logic signed [POS_W-1:0] pos_x_i;
  logic signed [POS_W-1:0] pos_y_i;
  logic signed [HEAD_W-1:0] heading_i;
  logic out_valid_o;
  logic out_stall_i;
  logic signed [POS_W-1:0] linear_speed_o;
  logic signed [RATE_W-1:0] angular_rate_o;
  logic goal_reached_o;
  logic goal_active_o;

  go_to_goal_tracker tracker = new();
  bit calm = 1'b0;
  bit hold_output = 1'b0;

  polar_go_to_goal_controller #(
    .CORDIC_STEPS(STEPS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .heading_i      (heading_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .linear_speed_o (linear_speed_o),
    .angular_rate_o (angular_rate_o),
    .goal_reached_o (goal_reached_o),
    .goal_active_o  (goal_active_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Results are checked before inputs are noted so a single edge stays ordered.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        tracker.check_command(linear_speed_o, angular_rate_o, goal_reached_o, goal_active_o);
      end
      if (in_valid_i && !in_stall_o) begin
        tracker.accept_item(action_i, pos_x_i, pos_y_i, heading_i);
      end
    end
  end

  function automatic int draw_idle();
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  initial begin : drain
    int n;
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_output) begin
        n = LONG_HOLD_CYCLES;
        hold_output = 1'b0;
      end else begin
        n = draw_idle();
      end
      if (n > 0) begin
        out_stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic send_item(input logic [1:0] act, input logic [31:0] px,
                           input logic [31:0] py, input logic [15:0] ph);
    int gap;
    gap = draw_idle();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i <= act;
    pos_x_i <= px;
    pos_y_i <= py;
    heading_i <= ph;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Waits until every owed command has come out, then lets the block go quiet.
  task automatic quiesce();
    in_valid_i <= 1'b0;
    // Waiting for the clock lets the monitor note the last transaction before the count is read.
    @(posedge clk_i);
    while (tracker.pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    tracker.set_reg(idx, data);
  endtask

  task automatic apply_settings(input int ph);
    logic [31:0] v [6];
    int i;
    for (i = 0; i < 6; i++) v[i] = $urandom;
    case (ph)
      0: begin
        v[0] = 32'h0000_7FFF; v[1] = 32'h0000_7FFF; v[2] = 32'h0000_7FFF;
        v[3] = 32'd0; v[4] = 32'd0;
      end
      1: begin
        v[0] = 32'hFFFF_8000; v[1] = 32'hFFFF_8000; v[2] = 32'hFFFF_8000;
        v[3] = 32'd1; v[4] = 32'd1; v[5] = 32'h8000_0000;
      end
      2: begin
        v[0] = 32'd0; v[1] = 32'd0; v[2] = 32'd0;
        v[3] = 32'hFFFF_FFFE; v[4] = 32'hFFFF_FFFF; v[5] = 32'h7FFF_FFFF;
      end
      3: begin
        v[0] = 32'(GAIN_DISTANCE_RST); v[1] = 32'(GAIN_BEARING_RST);
        v[2] = 32'(GAIN_FINAL_HEADING_RST); v[3] = 32'd1; v[4] = 32'd0;
      end
      default: ;
    endcase
    write_reg(CFG_GAIN_DISTANCE, v[0]);
    write_reg(CFG_GAIN_BEARING, v[1]);
    write_reg(CFG_GAIN_FINAL_HEADING, v[2]);
    write_reg(CFG_REVERSE_MODE, v[3]);
    write_reg(CFG_FIXED_SPEED_MODE, v[4]);
    write_reg(CFG_FIXED_SPEED, v[5]);
    write_reg(CFG_IDX_SPARE_LO, $urandom);
    write_reg(CFG_IDX_SPARE_HI, $urandom);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 1310720)) - 655360);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  function automatic logic [15:0] pick_heading();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return 16'($signed($urandom_range(0, 51472)) - 25736);
    if (r < 9) return 16'($urandom);
    case ($urandom_range(0, 3))
      0: return 16'(25736);
      1: return -16'sd25736;
      2: return 16'h7FFF;
      default: return 16'h8000;
    endcase
  endfunction

  // Mostly goal, pose, tick sequences that walk the robot around the goal so the
  // stop condition fires; some items are noise with any action and any fields.
  task automatic run_random(input int n);
    int k, steps, j;
    logic [1:0] act;
    logic [31:0] gx, gy, rx, ry;
    logic [15:0] gh, rh;
    k = 0;
    while (k < n) begin
      if ($urandom_range(0, 15) == 0) calm = !calm;
      if ($urandom_range(0, 9) == 0) begin
        act = 2'($urandom_range(0, 3));
        send_item(act, $urandom, $urandom, 16'($urandom));
        if (act != ACT_UNUSED) k++;
      end else begin
        gx = pick_coord();
        gy = pick_coord();
        gh = pick_heading();
        send_item(ACT_GOAL_POSE, gx, gy, gh);
        k++;
        steps = $urandom_range(1, 4);
        for (j = 0; j < steps; j++) begin
          if ($urandom_range(0, 1) == 1) begin
            rx = gx + 32'($signed($urandom_range(0, 30000)) - 15000);
            ry = gy + 32'($signed($urandom_range(0, 30000)) - 15000);
            rh = gh + 16'($signed($urandom_range(0, 2000)) - 1000);
          end else begin
            rx = pick_coord();
            ry = pick_coord();
            rh = pick_heading();
          end
          send_item(ACT_ROBOT_POSE, rx, ry, rh);
          send_item(ACT_TICK, $urandom, $urandom, 16'($urandom));
          k += 2;
        end
      end
    end
  endtask

  initial begin : stimulus
    int ph;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = CFG_GAIN_DISTANCE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    action_i = ACT_ROBOT_POSE;
    pos_x_i = '0;
    pos_y_i = '0;
    heading_i = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Tick before any goal, then a goal on top of the robot.
    send_item(ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_GOAL_POSE, 32'd0, 32'd0, 16'd0);
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    send_item(ACT_GOAL_POSE, 32'h0001_0000, 32'h0000_8000, 16'(25736));
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    // Opposite corners of the position range.
    send_item(ACT_ROBOT_POSE, 32'h8000_0000, 32'h8000_0000, 16'h8000);
    send_item(ACT_GOAL_POSE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h7FFF);
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    // Goal behind the robot, below and above the x axis.
    send_item(ACT_ROBOT_POSE, 32'h7FFF_FFFF, 32'd0, 16'(25736));
    send_item(ACT_GOAL_POSE, 32'h8000_0000, 32'hFFFF_FFFF, -16'sd25736);
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    send_item(ACT_GOAL_POSE, 32'h8000_0000, 32'd5, 16'd0);
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    // Close in position, headings on either side of the wrap point.
    send_item(ACT_ROBOT_POSE, 32'd0, 32'd0, 16'(25500));
    send_item(ACT_GOAL_POSE, 32'd13000, 32'd0, -16'sd25500);
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    // Heading error right at the stop threshold does not stop.
    send_item(ACT_ROBOT_POSE, 32'd0, 32'd0, 16'd0);
    send_item(ACT_GOAL_POSE, 32'd100, 32'd0, 16'(715));
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);
    send_item(ACT_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
    send_item(ACT_TICK, 32'd0, 32'd0, 16'd0);

    for (ph = 0; ph < PHASES; ph++) begin
      quiesce();
      apply_settings(ph);
      calm = (ph == 2);
      // Block the output for a long while so the block backs up onto its input.
      if (ph == 1) hold_output = 1'b1;
      run_random(ITEMS_PER_PHASE);
    end

    quiesce();
    if (tracker.mismatches == 0 && tracker.pending_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule

/* sim.f */
hdl/pgc_pkg.sv
hdl/pgc_mult.sv
hdl/pgc_cordic.sv
hdl/polar_go_to_goal_controller.sv
hdl/pgc_checker.sv
tb/polar_go_to_goal_controller_tb.sv
